FILE: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, widths and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int ADDR_W      = 20;
  localparam int LOG_W       = 5;
  localparam int MIN_LOG_DEF = 5;
  localparam int TOP_LOG_DEF = 19;

  localparam logic [ADDR_W-1:0] BASE_RST    = 20'h10000;
  localparam logic [LOG_W-1:0]  MAX_LOG_RST = 5'd16;

  typedef enum logic {
    REG_BASE    = 1'b0,
    REG_MAX_LOG = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_FREE   = 2'd1,
    ST_SPLIT  = 2'd2,
    ST_FULL   = 2'd3
  } node_st_t;

  // smallest k >= 1 with 2^k >= c
  function automatic logic [LOG_W-1:0] ceil_log(input logic [ADDR_W-1:0] c);
    logic [ADDR_W-1:0] m;
    logic [LOG_W-1:0]  k;
    m = c - ADDR_W'(1);
    k = LOG_W'(1);
    for (int i = 0; i < ADDR_W; i++) begin
      if (m[i]) k = LOG_W'(i + 1);
    end
    if (c <= ADDR_W'(2)) k = LOG_W'(1);
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: design/bba_store.sv
// ----------------------------------------------------------------------------
// bba_store
// Node status store: heap-indexed tree, one synchronous read and one write
// port. The root lives in a flop so that reset alone makes the tree valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_store #(
  parameter int IDX_W = 15
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output bba_pkg::node_st_t        rd_data,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire bba_pkg::node_st_t   wr_data
);
  import bba_pkg::*;

  localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

  node_st_t mem [2**IDX_W];
  node_st_t rd_q;
  node_st_t root;
  logic     rd_root;

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr != ROOT) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_root <= (rd_addr == ROOT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= ST_FREE;
    end else if (wr_en && wr_addr == ROOT) begin
      root <= wr_data;
    end
  end

  assign rd_data = rd_root ? root : rd_q;

endmodule

`default_nettype wire

FILE: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: tree search, split, release walk, buddy merge and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl #(
  parameter int MIN_LOG = bba_pkg::MIN_LOG_DEF,
  parameter int TOP_LOG = bba_pkg::TOP_LOG_DEF,
  parameter int IDX_W   = TOP_LOG - MIN_LOG + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         op,
  input  wire logic [bba_pkg::ADDR_W-1:0]   byte_count,
  input  wire logic [bba_pkg::ADDR_W-1:0]   block_start,
  input  wire logic [bba_pkg::ADDR_W-1:0]   base_address,
  input  wire logic [bba_pkg::LOG_W-1:0]    max_alloc_log,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              ok,
  output logic [bba_pkg::ADDR_W-1:0]        start_addr,
  output logic [bba_pkg::ADDR_W-1:0]        end_addr,
  output logic [bba_pkg::LOG_W-1:0]         block_log,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  wire bba_pkg::node_st_t            rd_data,
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output bba_pkg::node_st_t                 wr_data
);
  import bba_pkg::*;

  localparam logic [LOG_W-1:0] TOP_L = LOG_W'(TOP_LOG);
  localparam logic [LOG_W-1:0] MIN_L = LOG_W'(MIN_LOG);
  localparam logic [IDX_W-1:0] ROOT  = IDX_W'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP,
    S_A_RD, S_A_EV, S_A_NEXT, S_A_SPLIT, S_A_SIB, S_A_TAKE,
    S_R_RD, S_R_EV,
    S_FIN1, S_FIN2, S_LOAD, S_FAIL,
    S_M_RD, S_M_EV, S_M_WR
  } state_t;

  state_t               state;
  logic                 is_rel;
  logic [ADDR_W-1:0]    cnt;
  logic [ADDR_W-1:0]    off;
  logic [ADDR_W-1:0]    start_r;
  logic [ADDR_W-1:0]    end_r;
  logic [LOG_W-1:0]     want;
  logic [LOG_W-1:0]     lvl;
  logic [IDX_W-1:0]     n;

  logic [LOG_W-1:0]     k;
  logic [TOP_LOG:0]     n_sh;
  logic [ADDR_W-1:0]    lvl_mask;
  logic [ADDR_W-1:0]    off_sh;
  logic                 ld;

  assign k        = ceil_log(cnt);
  assign n_sh     = {{MIN_LOG{1'b0}}, n} << lvl;
  assign lvl_mask = (ADDR_W'(1) << lvl) - ADDR_W'(1);
  assign off_sh   = off >> (lvl - LOG_W'(1));
  assign ld       = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = n;
    wr_en   = 1'b0;
    wr_addr = n;
    wr_data = ST_FREE;
    case (state)
      S_A_RD, S_R_RD: rd_en = 1'b1;
      S_M_RD: begin
        rd_en   = (n != ROOT);
        rd_addr = n ^ IDX_W'(1);
      end
      S_A_SPLIT: begin
        wr_en   = 1'b1;
        wr_data = ST_SPLIT;
      end
      S_A_SIB: begin
        wr_en   = 1'b1;
        wr_addr = {n[IDX_W-2:0], 1'b1};
      end
      S_A_TAKE: begin
        wr_en   = 1'b1;
        wr_data = ST_FULL;
      end
      S_R_EV: wr_en = (rd_data == ST_FULL) &&
                      !(rd_data == ST_SPLIT && lvl > MIN_L) &&
                      ((off & lvl_mask) == '0);
      S_M_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_LOAD && state != S_FAIL) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_rel <= (op == OP_RELEASE);
            cnt    <= byte_count;
            off    <= block_start - base_address;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          n   <= ROOT;
          lvl <= TOP_L;
          if (is_rel) begin
            state <= ((off >> TOP_LOG) != '0) ? S_FAIL : S_R_RD;
          end else if (k > max_alloc_log || k > TOP_L) begin
            state <= S_FAIL;
          end else begin
            want  <= (k < MIN_L) ? MIN_L : k;
            state <= S_A_RD;
          end
        end
        S_A_RD: state <= S_A_EV;
        S_A_EV: begin
          if (lvl == want) begin
            state <= (rd_data == ST_FREE) ? S_A_TAKE : S_A_NEXT;
          end else if (rd_data == ST_SPLIT) begin
            n     <= {n[IDX_W-2:0], 1'b0};
            lvl   <= lvl - LOG_W'(1);
            state <= S_A_RD;
          end else if (rd_data == ST_FREE) begin
            state <= S_A_SPLIT;
          end else begin
            state <= S_A_NEXT;
          end
        end
        S_A_NEXT: begin
          if (n == ROOT) begin
            state <= S_FAIL;
          end else if (!n[0]) begin
            n     <= n + IDX_W'(1);
            state <= S_A_RD;
          end else begin
            n   <= n >> 1;
            lvl <= lvl + LOG_W'(1);
          end
        end
        S_A_SPLIT: state <= S_A_SIB;
        S_A_SIB: begin
          n     <= {n[IDX_W-2:0], 1'b0};
          lvl   <= lvl - LOG_W'(1);
          state <= (lvl - LOG_W'(1) == want) ? S_A_TAKE : S_A_SPLIT;
        end
        S_A_TAKE: begin
          off   <= ADDR_W'(n_sh[TOP_LOG-1:0]);
          state <= S_FIN1;
        end
        S_R_RD: state <= S_R_EV;
        S_R_EV: begin
          if (rd_data == ST_SPLIT && lvl > MIN_L) begin
            lvl   <= lvl - LOG_W'(1);
            n     <= {n[IDX_W-2:0], off_sh[0]};
            state <= S_R_RD;
          end else if (rd_data == ST_FULL && (off & lvl_mask) == '0) begin
            state <= S_FIN1;
          end else begin
            state <= S_FAIL;
          end
        end
        S_FIN1: begin
          start_r <= base_address + off;
          state   <= S_FIN2;
        end
        S_FIN2: begin
          end_r <= start_r + lvl_mask;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (ld) begin
            out_valid  <= 1'b1;
            ok         <= 1'b1;
            start_addr <= start_r;
            end_addr   <= end_r;
            block_log  <= lvl;
            state      <= is_rel ? S_M_RD : S_IDLE;
          end
        end
        S_FAIL: begin
          if (ld) begin
            out_valid  <= 1'b1;
            ok         <= 1'b0;
            start_addr <= '0;
            end_addr   <= '0;
            block_log  <= '0;
            state      <= S_IDLE;
          end
        end
        S_M_RD: state <= (n == ROOT) ? S_IDLE : S_M_EV;
        S_M_EV: begin
          if (rd_data == ST_FREE) begin
            n     <= n >> 1;
            state <= S_M_WR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_M_WR: state <= S_M_RD;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/buddy_block_allocator_top.sv
// Allocate walks the tree from the root, reading nodes, splitting and backtracking
// as needed; release walks down to the block. A failure result loads once the walk
// or check ends and the output can take it. A stalled result holds the sequencer.
// After a release beat, merging keeps in_ready low until the merge walk ends.
// One request at a time. Reset: root status is a flop, other nodes are written
// before they are read, no clearing pass; registers reset to 0x10000 and 16.
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator with config registers, sequencer and node store.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_top #(
  parameter int MIN_LOG = bba_pkg::MIN_LOG_DEF,
  parameter int TOP_LOG = bba_pkg::TOP_LOG_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        op,
  input  wire logic [bba_pkg::ADDR_W-1:0]  byte_count,
  input  wire logic [bba_pkg::ADDR_W-1:0]  block_start,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             ok,
  output logic [bba_pkg::ADDR_W-1:0]       start_addr,
  output logic [bba_pkg::ADDR_W-1:0]       end_addr,
  output logic [bba_pkg::LOG_W-1:0]        block_log
);
  import bba_pkg::*;

  localparam int IDX_W = TOP_LOG - MIN_LOG + 1;

  logic [ADDR_W-1:0] base_address;
  logic [LOG_W-1:0]  max_alloc_log;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  node_st_t          rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  node_st_t          wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= BASE_RST;
      max_alloc_log <= MAX_LOG_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE:    base_address  <= cfg_data;
        REG_MAX_LOG: max_alloc_log <= cfg_data[LOG_W-1:0];
        default: ;
      endcase
    end
  end

  bba_ctrl #(
    .MIN_LOG(MIN_LOG),
    .TOP_LOG(TOP_LOG),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .byte_count   (byte_count),
    .block_start  (block_start),
    .base_address (base_address),
    .max_alloc_log(max_alloc_log),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .start_addr   (start_addr),
    .end_addr     (end_addr),
    .block_log    (block_log),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  bba_store #(
    .IDX_W(IDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

`default_nettype wire

FILE: sim/tb_buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// Drives allocate and release requests into the buddy allocator and checks
// every response beat against a tree-based predictor kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_buddy_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int MINL = 5;
  localparam int TOPL = 19;
  localparam int NNODES = 1 << (TOPL - MINL + 1);
  localparam longint CYCLE_LIMIT = 500000000;

  typedef struct packed {
    logic                ok;
    logic [ADDR_W-1:0]   start_addr;
    logic [ADDR_W-1:0]   end_addr;
    logic [LOG_W-1:0]    block_log;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [ADDR_W-1:0] byte_count = '0;
  logic [ADDR_W-1:0] block_start = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  logic [ADDR_W-1:0] start_addr, end_addr;
  logic [LOG_W-1:0] block_log;

  buddy_block_allocator_top dut (.*);

  node_st_t tree [NNODES];
  logic [ADDR_W-1:0] base_q;
  logic [LOG_W-1:0] maxlog_q;
  resp_t pending_resp [$];
  logic [ADDR_W-1:0] live_blocks [$];
  int errors = 0;
  int resp_count = 0;
  int ok_allocs = 0;
  longint cycles = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_top test failed");
      $finish;
    end
  end

  function automatic int descend(int n, int level, int want);
    int r;
    if (level == want) begin
      if (tree[n] == ST_FREE) begin
        tree[n] = ST_FULL;
        return n;
      end
      return 0;
    end
    if (level <= MINL) return 0;
    if (tree[n] == ST_SPLIT) begin
      r = descend(2 * n, level - 1, want);
      if (r != 0) return r;
      return descend(2 * n + 1, level - 1, want);
    end
    if (tree[n] == ST_FREE) begin
      tree[n] = ST_SPLIT;
      tree[2 * n] = ST_FREE;
      tree[2 * n + 1] = ST_FREE;
      return descend(2 * n, level - 1, want);
    end
    return 0;
  endfunction

  function automatic resp_t block_resp(logic [ADDR_W-1:0] offs, int level);
    resp_t r;
    r.ok = 1'b1;
    r.start_addr = base_q + offs;
    r.end_addr = r.start_addr + ADDR_W'((longint'(1) << level) - 1);
    r.block_log = LOG_W'(level);
    return r;
  endfunction

  function automatic resp_t predict_alloc(logic [ADDR_W-1:0] cnt);
    resp_t r;
    int k;
    int n;
    r = '0;
    k = 1;
    while ((longint'(1) << k) < longint'(cnt)) k++;
    if (k > maxlog_q || k > TOPL) return r;
    if (k < MINL) k = MINL;
    n = descend(1, TOPL, k);
    if (n == 0) return r;
    return block_resp(ADDR_W'((n - (1 << (TOPL - k))) << k), k);
  endfunction

  function automatic resp_t predict_release(logic [ADDR_W-1:0] addr);
    resp_t r;
    logic [ADDR_W-1:0] offs;
    int n;
    int level;
    r = '0;
    offs = addr - base_q;
    n = 1;
    level = TOPL;
    if (longint'(offs) >= (longint'(1) << TOPL)) return r;
    while (tree[n] == ST_SPLIT && level > MINL) begin
      level--;
      n = 2 * n + int'(offs[level]);
    end
    if (tree[n] != ST_FULL) return r;
    if ((longint'(offs) & ((longint'(1) << level) - 1)) != 0) return r;
    tree[n] = ST_FREE;
    r = block_resp(offs, level);
    while (n > 1 && tree[n ^ 1] == ST_FREE) begin
      tree[n] = ST_ABSENT;
      tree[n ^ 1] = ST_ABSENT;
      n = n >> 1;
      tree[n] = ST_FREE;
    end
    return r;
  endfunction

  task automatic reset_tree();
    foreach (tree[i]) tree[i] = ST_ABSENT;
    tree[1] = ST_FREE;
    base_q = BASE_RST;
    maxlog_q = MAX_LOG_RST;
    live_blocks.delete();
  endtask

  // sender gap drawn per beat; response beat predicted at acceptance
  task automatic send_req(op_t o, logic [ADDR_W-1:0] cnt, logic [ADDR_W-1:0] addr);
    resp_t r;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    byte_count <= cnt;
    block_start <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == OP_ALLOC) begin
      r = predict_alloc(cnt);
      if (r.ok) live_blocks.push_back(r.start_addr);
    end else begin
      r = predict_release(addr);
      foreach (live_blocks[i]) begin
        if (r.ok && live_blocks[i] == addr) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    pending_resp.push_back(r);
  endtask

  initial begin
    int wait_left;
    resp_t e;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        resp_count++;
        if (pending_resp.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = pending_resp.pop_front();
          if (ok !== e.ok) begin
            $error("ok exp %0h got %0h", e.ok, ok); errors++;
          end
          if (start_addr !== e.start_addr) begin
            $error("start_addr exp %0h got %0h", e.start_addr, start_addr); errors++;
          end
          if (end_addr !== e.end_addr) begin
            $error("end_addr exp %0h got %0h", e.end_addr, end_addr); errors++;
          end
          if (block_log !== e.block_log) begin
            $error("block_log exp %0h got %0h", e.block_log, block_log); errors++;
          end
          if (e.ok && e.start_addr != 0) ok_allocs++;
        end
      end
      if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else if (out_ready && out_valid) begin
        wait_left = $urandom_range(0, 4);
        out_ready <= (wait_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [ADDR_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE) base_q = val;
    else maxlog_q = val[LOG_W-1:0];
  endtask

  task automatic release_all();
    logic [ADDR_W-1:0] a;
    while (live_blocks.size() != 0) begin
      a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      send_req(OP_RELEASE, '0, a);
    end
  endtask

  task automatic test_directed();
    send_req(OP_ALLOC, 20'd0, 20'hFFFFF);
    send_req(OP_ALLOC, 20'd1, '0);
    send_req(OP_ALLOC, 20'd33, '0);
    send_req(OP_ALLOC, 20'd65536, '0);
    send_req(OP_ALLOC, 20'd65537, '0);
    send_req(OP_ALLOC, 20'hFFFFF, '0);
    send_req(OP_RELEASE, 20'hFFFFF, 20'h10000 + 20'd1);
    send_req(OP_RELEASE, '0, 20'h0);
    send_req(OP_RELEASE, '0, 20'hFFFFF);
    send_req(OP_RELEASE, '0, 20'h10020);
    send_req(OP_RELEASE, '0, 20'h10020);
    send_req(OP_RELEASE, '0, 20'h10000);
    release_all();
  endtask

  task automatic test_full_region();
    write_reg(REG_MAX_LOG, 20'd19);
    write_reg(REG_BASE, 20'hFFFFF);
    send_req(OP_ALLOC, 20'd524288, '0);
    send_req(OP_ALLOC, 20'd32, '0);
    send_req(OP_ALLOC, 20'd524289, '0);
    release_all();
    write_reg(REG_MAX_LOG, 20'd31);
    send_req(OP_ALLOC, 20'hFFFFF, '0);
    write_reg(REG_MAX_LOG, 20'd5);
    send_req(OP_ALLOC, 20'd32, '0);
    send_req(OP_ALLOC, 20'd33, '0);
    release_all();
  endtask

  task automatic random_phase(int n);
    logic [ADDR_W-1:0] cnt, a;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        cnt = (sel < 40) ? ADDR_W'($urandom_range(0, 1 << $urandom_range(0, 16)))
                         : ADDR_W'($urandom);
        send_req(OP_ALLOC, cnt, ADDR_W'($urandom));
      end else if (sel < 88 && live_blocks.size() != 0) begin
        a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        send_req(OP_RELEASE, ADDR_W'($urandom), a);
      end else begin
        a = (sel < 94 && live_blocks.size() != 0)
            ? live_blocks[$urandom_range(0, live_blocks.size() - 1)] + ADDR_W'(32)
            : ADDR_W'($urandom);
        send_req(OP_RELEASE, ADDR_W'($urandom), a);
      end
    end
    release_all();
  endtask

  task automatic test_random();
    write_reg(REG_BASE, 20'h0);
    write_reg(REG_MAX_LOG, 20'd16);
    random_phase(500);
    write_reg(REG_BASE, ADDR_W'($urandom));
    write_reg(REG_MAX_LOG, 20'd19);
    random_phase(500);
    write_reg(REG_BASE, 20'hC0000);
    write_reg(REG_MAX_LOG, 20'd10);
    random_phase(550);
  endtask

  initial begin
    reset_tree();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_region();
    test_random();
    drain();
    $display("covered %0d response beats over several base/max-size settings,",
             resp_count);
    $display("  %0d grants or releases with a nonzero start", ok_allocs);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("buddy_block_allocator_top test passed");
    end else begin
      $display("buddy_block_allocator_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/bba_pkg.sv
design/bba_store.sv
design/bba_ctrl.sv
design/buddy_block_allocator_top.sv
sim/tb_buddy_block_allocator_top.sv
